// ===== rtl/core/abrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrs_pkg: shared types and codes for adaptive bubble route selection
// Port, channel class, status and register codes plus the structs that move
// configuration and route results between modules.
// ----------------------------------------------------------------------------
package abrs_pkg;

  localparam int OffsetW  = 7;
  localparam int PortW    = 3;
  localparam int ChanW    = 4;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  // output ports, also used as input direction codes
  localparam logic [PortW-1:0] PORT_XP    = 3'd0;
  localparam logic [PortW-1:0] PORT_XM    = 3'd1;
  localparam logic [PortW-1:0] PORT_YP    = 3'd2;
  localparam logic [PortW-1:0] PORT_YM    = 3'd3;
  localparam logic [PortW-1:0] PORT_LOCAL = 3'd4;

  // channel classes
  localparam logic [ChanW-1:0] CH_NONE  = 4'd0;
  localparam logic [ChanW-1:0] CH_ADAPT = 4'd1;
  localparam logic [ChanW-1:0] CH_DOR   = 4'd2;

  // route status
  localparam logic [StatusW-1:0] ST_GRANT = 2'd0;
  localparam logic [StatusW-1:0] ST_BLOCK = 2'd1;
  localparam logic [StatusW-1:0] ST_ERROR = 2'd2;

  // request phases
  localparam logic [1:0] PH_ADAPT_OWN   = 2'd0;
  localparam logic [1:0] PH_ADAPT_OTHER = 2'd1;
  localparam logic [1:0] PH_DOR_X       = 2'd2;
  localparam logic [1:0] PH_DOR_Y       = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_INPUT_DIRECTION     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_INPUT_CHANNEL_CLASS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LOCAL_PORT_COUNT    = 2'd2;

  typedef struct packed {
    logic [2:0] input_direction;
    logic [1:0] input_channel_class;
    logic [3:0] local_port_count;
  } cfg_t;

  typedef struct packed {
    logic [StatusW-1:0] route_status;
    logic [PortW-1:0]   out_port;
    logic [ChanW-1:0]   out_channel;
  } res_t;

endpackage

// ===== rtl/core/abrs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrs_if: handshake channels for route requests, results and configuration
// Each channel carries valid, ready and its payload fields.
// ----------------------------------------------------------------------------
interface abrs_req_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] offset_first;
  logic signed [6:0] offset_second;
  logic              bubble_x_plus;
  logic              bubble_x_minus;
  logic              bubble_y_plus;
  logic              bubble_y_minus;

  modport source (output valid, offset_first, offset_second, bubble_x_plus,
                  bubble_x_minus, bubble_y_plus, bubble_y_minus, input ready);
  modport sink   (input valid, offset_first, offset_second, bubble_x_plus,
                  bubble_x_minus, bubble_y_plus, bubble_y_minus, output ready);
endinterface

interface abrs_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] route_status;
  logic [2:0] out_port;
  logic [3:0] out_channel;

  modport source (output valid, route_status, out_port, out_channel, input ready);
  modport sink   (input valid, route_status, out_port, out_channel, output ready);
endinterface

interface abrs_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/abrs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrs_cfg_regs: configuration register file
// Takes register writes from the configuration channel, one per cycle.
// ----------------------------------------------------------------------------
module abrs_cfg_regs
  import abrs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  abrs_cfg_if.sink cfg_if,
  output cfg_t cfg
);

  cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_direction     <= PORT_LOCAL;
      cfg_r.input_channel_class <= 2'(CH_ADAPT);
      cfg_r.local_port_count    <= 4'd1;
    end else if (cfg_if.valid) begin
      // writes beyond the register list drop silently
      case (cfg_if.index)
        REG_INPUT_DIRECTION:     cfg_r.input_direction     <= cfg_if.data[2:0];
        REG_INPUT_CHANNEL_CLASS: cfg_r.input_channel_class <= cfg_if.data[1:0];
        REG_LOCAL_PORT_COUNT:    cfg_r.local_port_count    <= cfg_if.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/abrs_route_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abrs_route_calc: single-pass route decision
// Picks the first firing try from the current phase, applies the bubble check
// and computes the next phase and local consumer counter.
// ----------------------------------------------------------------------------
module abrs_route_calc
  import abrs_pkg::*;
#(
  parameter int MAX_LOCAL_PORTS = 8
) (
  input  cfg_t              cfg,
  input  logic [1:0]        phase,
  input  logic [3:0]        lp_cnt,
  input  logic signed [6:0] offset_first,
  input  logic signed [6:0] offset_second,
  input  logic [3:0]        bubble,      // {y-, y+, x-, x+}
  output res_t              res,
  output logic [1:0]        phase_nxt,
  output logic [3:0]        lp_cnt_nxt
);

  localparam logic [3:0] MaxLp = 4'(MAX_LOCAL_PORTS);

  logic       done0, done1, big0, big1;
  logic       xside, yside, dir_ok, dor_class;
  logic [3:0] fire;

  function automatic logic is_big(input logic signed [6:0] v);
    is_big = !(v == 7'sd0 || v == 7'sd1 || v == -7'sd1);
  endfunction

  assign done0     = (offset_first == 7'sd1) || (offset_first == -7'sd1);
  assign done1     = (offset_second == 7'sd1) || (offset_second == -7'sd1);
  assign big0      = is_big(offset_first);
  assign big1      = is_big(offset_second);
  assign xside     = (cfg.input_direction <= PORT_XM) || (cfg.input_direction == PORT_LOCAL);
  assign yside     = (cfg.input_direction == PORT_YP) || (cfg.input_direction == PORT_YM);
  assign dir_ok    = (cfg.input_direction <= PORT_LOCAL);
  assign dor_class = (cfg.input_direction != PORT_LOCAL) &&
                     (cfg.input_channel_class != 2'(CH_ADAPT));

  assign fire[PH_ADAPT_OWN]   = xside ? big0 : big1;
  assign fire[PH_ADAPT_OTHER] = yside ? big0 : big1;
  assign fire[PH_DOR_X]       = big0;
  assign fire[PH_DOR_Y]       = big1;

  always_comb begin
    logic [1:0]        k;
    logic [1:0]        sel;
    logic              found;
    logic signed [6:0] d;
    logic              pos;
    logic [PortW-1:0]  nd;
    logic [3:0]        lp;
    logic [3:0]        base;

    sel   = phase;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      k = phase + 2'(i);
      if (!found && fire[k]) begin
        found = 1'b1;
        sel   = k;
      end
    end

    case (sel)
      PH_ADAPT_OWN:   d = xside ? offset_first : offset_second;
      PH_ADAPT_OTHER: d = yside ? offset_first : offset_second;
      PH_DOR_X:       d = offset_first;
      default:        d = offset_second;
    endcase
    pos = !d[6];   // d is nonzero once the try fires

    res        = '{route_status: ST_ERROR, out_port: PORT_XP, out_channel: CH_NONE};
    phase_nxt  = phase;
    lp_cnt_nxt = lp_cnt;

    lp   = (cfg.local_port_count > MaxLp) ? MaxLp : cfg.local_port_count;
    base = (lp_cnt >= lp) ? 4'd0 : lp_cnt;
    nd   = PORT_XP;

    if (done0 && done1) begin
      lp_cnt_nxt = base + 4'd1;
      res = '{route_status: ST_GRANT, out_port: PORT_LOCAL, out_channel: base + 4'd1};
    end else if (dir_ok && found) begin
      case (sel)
        PH_ADAPT_OWN: begin
          phase_nxt       = PH_ADAPT_OTHER;
          res.route_status = ST_GRANT;
          res.out_channel  = CH_ADAPT;
          if (cfg.input_direction != PORT_LOCAL) begin
            res.out_port = cfg.input_direction;
          end else begin
            res.out_port = pos ? PORT_XP : PORT_XM;
          end
        end
        PH_ADAPT_OTHER: begin
          phase_nxt        = PH_DOR_X;
          res.route_status = ST_GRANT;
          res.out_channel  = CH_ADAPT;
          if (yside) begin
            res.out_port = pos ? PORT_XP : PORT_XM;
          end else begin
            res.out_port = pos ? PORT_YP : PORT_YM;
          end
        end
        default: begin
          phase_nxt = PH_ADAPT_OWN;
          if (sel == PH_DOR_X) begin
            nd = pos ? PORT_XP : PORT_XM;
          end else begin
            nd = pos ? PORT_YP : PORT_YM;
          end
          if (dor_class && cfg.input_direction == nd) begin
            res = '{route_status: ST_GRANT, out_port: nd, out_channel: CH_DOR};
          end else if (dor_class && nd <= PORT_XM) begin
            res = '{route_status: ST_ERROR, out_port: PORT_XP, out_channel: CH_NONE};
          end else begin
            res = '{route_status: bubble[nd[1:0]] ? ST_GRANT : ST_BLOCK,
                    out_port: nd, out_channel: CH_DOR};
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/adaptive_bubble_route_select.sv =====
// A result appears in the output register in the cycle after its request transfers.
// Throughput: one request per cycle while the sink is ready; the phase and local counter
//   update in the same cycle, so each decision sees the state left by the one before it.
// Reset: synchronous active-low rst_n clears the phase to the first adaptive try,
//   the local counter to zero, the output valid, and restores configuration defaults.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_bubble_route_select: route selection for one torus router input
// Registered single-pass decision between the request channel and a result
// register that also acts as the output skid stage.
// ----------------------------------------------------------------------------
module adaptive_bubble_route_select
  import abrs_pkg::*;
#(
  parameter int MAX_LOCAL_PORTS = 8
) (
  input  logic clk,
  input  logic rst_n,
  abrs_req_if.sink   in_if,
  abrs_res_if.source out_if,
  abrs_cfg_if.sink   cfg_if
);

  cfg_t       cfg;
  res_t       res, out_res_r;
  logic       out_valid_r;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] lp_cnt_r, lp_cnt_nxt;
  logic       in_fire;

  // Config registers: own block. The user must send writes only while idle; not enforced.
  abrs_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // Whole decision for one request: try selection, bubble check, next state.
  abrs_route_calc #(
    .MAX_LOCAL_PORTS (MAX_LOCAL_PORTS)
  ) u_calc (
    .cfg           (cfg),
    .phase         (phase_r),
    .lp_cnt        (lp_cnt_r),
    .offset_first  (in_if.offset_first),
    .offset_second (in_if.offset_second),
    .bubble        ({in_if.bubble_y_minus, in_if.bubble_y_plus,
                     in_if.bubble_x_minus, in_if.bubble_x_plus}),
    .res           (res),
    .phase_nxt     (phase_nxt),
    .lp_cnt_nxt    (lp_cnt_nxt)
  );

  // Accept a new request whenever the result register is empty or drains this cycle.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid        = out_valid_r;
  assign out_if.route_status = out_res_r.route_status;
  assign out_if.out_port     = out_res_r.out_port;
  assign out_if.out_channel  = out_res_r.out_channel;

  // Control state: advance phase and counter only on a request transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_ADAPT_OWN;
      lp_cnt_r    <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        lp_cnt_r    <= lp_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on transfer, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_res_r <= res;
    end
  end

  // A pending result never blocks intake when the sink takes it.
  a_ready_when_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_if.ready) |-> in_if.ready)
    else $error("request channel stalled while result register drains");

  // Errors carry port X+ and channel zero.
  a_error_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.route_status == ST_ERROR) |->
      (out_res_r.out_port == PORT_XP && out_res_r.out_channel == CH_NONE))
    else $error("routing error with nonzero port or channel");

  // Local grants hand out a consumer within 1..MAX_LOCAL_PORTS.
  a_local_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.out_port == PORT_LOCAL) |->
      (out_res_r.out_channel != 4'd0 && out_res_r.out_channel <= 4'(MAX_LOCAL_PORTS)))
    else $error("local consumer number out of range");

  // A dimension-order result restarts the tries at the first adaptive phase.
  a_dor_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res.out_port != PORT_LOCAL && res.out_channel == CH_DOR) |=>
      (phase_r == PH_ADAPT_OWN))
    else $error("phase not restarted after dimension-order try");

  // The local counter moves only on a request transfer.
  a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(lp_cnt_r))
    else $error("local counter changed without a request transfer");

endmodule

// ===== tb/tb_adaptive_bubble_route_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_bubble_route_select: self-checking bench for route selection
// Feeds header route requests through the request channel, predicts every
// route result from a shadow of the phase, local counter and configuration,
// and checks each result transfer in order. The configuration is rewritten
// between drained phases, covering local, X and Y inputs, both channel
// classes, undefined directions and local counts from zero past the cap.
// ----------------------------------------------------------------------------
module tb_adaptive_bubble_route_select;
  import abrs_pkg::*;

  localparam int MAX_LOCAL  = 8;     // matches the block's default parameter
  localparam int PHASE_REQS = 119;   // random requests per configuration phase
  localparam int NUM_PHASES = 12;
  localparam int STALL_LIMIT = 1000; // cycles without any transfer

  typedef struct {
    logic signed [OffsetW-1:0] off_a;
    logic signed [OffsetW-1:0] off_b;
    logic [3:0]                bubbles;   // {y-, y+, x-, x+}
    bit                        hold;      // wait for all results before issue
  } route_req_t;

  logic clk = 1'b0;
  logic rst_n;

  abrs_req_if req_ch ();
  abrs_res_if res_ch ();
  abrs_cfg_if cfg_ch ();

  adaptive_bubble_route_select DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block's registers and kept state
  logic [2:0] sh_dir;
  logic [1:0] sh_cls;
  logic [3:0] sh_count;
  logic [1:0] sh_phase;
  logic [3:0] sh_local;

  route_req_t pending_req_q[$];
  res_t       route_expect_q[$];
  int         reqs_queued;
  int         reqs_taken;
  int         mismatches;
  int         results_seen;
  int         idle_cycles;
  int         cyc;
  bit         hold_next;
  logic       quiet;

  // Give both sides a recurring stretch with no idling.
  assign quiet = (cyc % 3000) < 700;

  function automatic int mag7(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Work out the route result for one request and advance the shadow state.
  function automatic res_t route_decide(input logic signed [OffsetW-1:0] off_a,
                                        input logic signed [OffsetW-1:0] off_b,
                                        input logic [3:0] bub);
    res_t       r;
    int         oa;
    int         ob;
    int         d;
    logic [1:0] ph;
    logic [1:0] tp;
    logic [2:0] nd;
    logic [3:0] cap;
    bit         x_side;
    bit         y_side;
    bit         done;
    oa = off_a;
    ob = off_b;
    r.route_status = ST_ERROR;
    r.out_port     = PORT_XP;
    r.out_channel  = CH_NONE;

    // Arrived in both dimensions: hand out the next local consumer.
    if (mag7(oa) == 1 && mag7(ob) == 1) begin
      cap = (sh_count > MAX_LOCAL) ? 4'(MAX_LOCAL) : sh_count;
      if (sh_local >= cap) sh_local = '0;
      sh_local = sh_local + 4'd1;
      r.route_status = ST_GRANT;
      r.out_port     = PORT_LOCAL;
      r.out_channel  = sh_local;
      return r;
    end

    // Undefined input direction: error, phase left alone.
    if (sh_dir > PORT_LOCAL) return r;

    x_side = (sh_dir <= PORT_XM) || (sh_dir == PORT_LOCAL);
    y_side = (sh_dir == PORT_YP) || (sh_dir == PORT_YM);
    ph     = sh_phase;
    done   = 1'b0;
    for (int i = 0; i < 4 && !done; i++) begin
      tp = ph;
      ph = ph + 2'd1;
      case (tp)
        PH_ADAPT_OWN: begin
          d = x_side ? oa : ob;
          if (mag7(d) > 1) begin
            done = 1'b1;
            r.route_status = ST_GRANT;
            r.out_channel  = CH_ADAPT;
            if (sh_dir != PORT_LOCAL) r.out_port = sh_dir;
            else r.out_port = (d > 0) ? PORT_XP : PORT_XM;
          end
        end
        PH_ADAPT_OTHER: begin
          d = y_side ? oa : ob;
          if (mag7(d) > 1) begin
            done = 1'b1;
            r.route_status = ST_GRANT;
            r.out_channel  = CH_ADAPT;
            if (y_side) r.out_port = (d > 0) ? PORT_XP : PORT_XM;
            else r.out_port = (d > 0) ? PORT_YP : PORT_YM;
          end
        end
        default: begin
          d = (tp == PH_DOR_X) ? oa : ob;
          if (mag7(d) > 1) begin
            done = 1'b1;
            ph   = PH_ADAPT_OWN;
            if (tp == PH_DOR_X) nd = (d > 0) ? PORT_XP : PORT_XM;
            else nd = (d > 0) ? PORT_YP : PORT_YM;
            if (sh_dir != PORT_LOCAL && sh_cls != CH_ADAPT && sh_dir == nd) begin
              // dimension-order channel going straight on
              r.route_status = ST_GRANT;
              r.out_port     = nd;
              r.out_channel  = CH_DOR;
            end else if (sh_dir != PORT_LOCAL && sh_cls != CH_ADAPT && nd <= PORT_XM) begin
              // turn back into X on a dimension-order channel
              r.route_status = ST_ERROR;
              r.out_port     = PORT_XP;
              r.out_channel  = CH_NONE;
            end else begin
              r.route_status = bub[nd] ? ST_GRANT : ST_BLOCK;
              r.out_port     = nd;
              r.out_channel  = CH_DOR;
            end
          end
        end
      endcase
    end
    sh_phase = ph;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Request driver: present pending requests, predict on each transfer.
  always @(posedge clk) begin : req_driver
    route_req_t nxt;
    logic       go;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        route_expect_q.push_back(route_decide(req_ch.offset_first, req_ch.offset_second,
                                              {req_ch.bubble_y_minus, req_ch.bubble_y_plus,
                                               req_ch.bubble_x_minus, req_ch.bubble_x_plus}));
        reqs_taken++;
      end
      // Hold the current request until it transfers; then pick the next one.
      if (!req_ch.valid || req_ch.ready) begin
        go = (pending_req_q.size() != 0) && (quiet || $urandom_range(0, 99) >= 10);
        if (go && pending_req_q[0].hold && route_expect_q.size() != 0) go = 1'b0;
        if (go) begin
          nxt = pending_req_q.pop_front();
          req_ch.offset_first   <= nxt.off_a;
          req_ch.offset_second  <= nxt.off_b;
          req_ch.bubble_x_plus  <= nxt.bubbles[0];
          req_ch.bubble_x_minus <= nxt.bubbles[1];
          req_ch.bubble_y_plus  <= nxt.bubbles[2];
          req_ch.bubble_y_minus <= nxt.bubbles[3];
          req_ch.valid          <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, check each result transfer in order.
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (route_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results_seen));
        end else begin
          want = route_expect_q.pop_front();
          if (res_ch.route_status !== want.route_status)
            report_mismatch($sformatf("result %0d route_status %0d, expected %0d",
                                      results_seen, res_ch.route_status, want.route_status));
          if (res_ch.out_port !== want.out_port)
            report_mismatch($sformatf("result %0d out_port %0d, expected %0d",
                                      results_seen, res_ch.out_port, want.out_port));
          if (res_ch.out_channel !== want.out_channel)
            report_mismatch($sformatf("result %0d out_channel %0d, expected %0d",
                                      results_seen, res_ch.out_channel, want.out_channel));
        end
      end
      res_ch.ready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  // Watchdog: end the run if no channel moves for too long.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_req(input logic signed [OffsetW-1:0] a,
                         input logic signed [OffsetW-1:0] b,
                         input logic [3:0] bub);
    route_req_t q;
    q.off_a   = a;
    q.off_b   = b;
    q.bubbles = bub;
    q.hold    = hold_next;
    hold_next = 1'b0;
    pending_req_q.push_back(q);
    reqs_queued++;
  endtask

  function automatic logic [3:0] pick_bubbles();
    logic [3:0] b;
    for (int i = 0; i < 4; i++) b[i] = ($urandom_range(0, 3) != 0);
    return b;
  endfunction

  // Mix of arrived, zero, near, far and raw 7-bit offsets.
  function automatic logic signed [OffsetW-1:0] pick_offset();
    int r;
    int m;
    r = $urandom_range(0, 99);
    if (r >= 88) return OffsetW'($urandom_range(0, 127));
    if (r < 25) m = 1;
    else if (r < 32) m = 0;
    else if (r < 75) m = $urandom_range(2, 8);
    else m = $urandom_range(30, 32);
    return $urandom_range(0, 1) ? OffsetW'(-m) : OffsetW'(m);
  endfunction

  // One packet walking hop by hop toward its destination, with retries,
  // ending in the local delivery request.
  task automatic add_journey();
    int a;
    int b;
    a = $urandom_range(1, 6);
    b = $urandom_range(1, 6);
    if ($urandom_range(0, 1)) a = -a;
    if ($urandom_range(0, 1)) b = -b;
    while (!(mag7(a) == 1 && mag7(b) == 1)) begin
      add_req(OffsetW'(a), OffsetW'(b), pick_bubbles());
      if ($urandom_range(0, 4) != 0) begin
        // advance one dimension that still has hops left
        if (mag7(a) > 1 && (mag7(b) <= 1 || $urandom_range(0, 1))) a = (a > 0) ? a - 1 : a + 1;
        else b = (b > 0) ? b - 1 : b + 1;
      end
    end
    add_req(OffsetW'(a), OffsetW'(b), pick_bubbles());
  endtask

  task automatic fill_phase(input int n);
    int target;
    bit held;
    target = reqs_queued + n;
    held   = 1'b0;
    while (reqs_queued < target) begin
      // once per phase, stop issuing until every result is back
      if (!held && reqs_queued >= target - n / 2) begin
        hold_next = 1'b1;
        held      = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) add_journey();
      else add_req(pick_offset(), pick_offset(), pick_bubbles());
    end
  endtask

  task automatic wait_drained();
    while (reqs_taken != reqs_queued || route_expect_q.size() != 0) @(posedge clk);
    // allow for the output register stage
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_INPUT_DIRECTION:     sh_dir   = val[2:0];
      REG_INPUT_CHANNEL_CLASS: sh_cls   = val[1:0];
      REG_LOCAL_PORT_COUNT:    sh_count = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [3:0] dir_tab[NUM_PHASES];
    logic [3:0] cls_tab[NUM_PHASES];
    logic [3:0] cnt_tab[NUM_PHASES];

    // Phase 0 runs on the reset configuration; the rest rewrite all registers.
    // Direction 13 and class 14 check that only the low bits are kept.
    dir_tab = '{4'd4, 4'd0, 4'd1, 4'd2, 4'd3, 4'd3, 4'd0, 4'd7, 4'd4, 4'd13, 4'd2, 4'd0};
    cls_tab = '{4'd1, 4'd1, 4'd2, 4'd2, 4'd0, 4'd2, 4'd2, 4'd3, 4'd14, 4'd1, 4'd1, 4'd0};
    cnt_tab = '{4'd1, 4'd3, 4'd8, 4'd15, 4'd0, 4'd5, 4'd2, 4'd9, 4'd4, 4'd1, 4'd6, 4'd0};

    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.offset_first = '0;
    req_ch.offset_second = '0;
    req_ch.bubble_x_plus = 1'b0;
    req_ch.bubble_x_minus = 1'b0;
    req_ch.bubble_y_plus = 1'b0;
    req_ch.bubble_y_minus = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sh_dir = PORT_LOCAL;
    sh_cls = 2'd1;
    sh_count = 4'd1;
    sh_phase = PH_ADAPT_OWN;
    sh_local = '0;
    reqs_queued = 0;
    reqs_taken = 0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    cyc = 0;
    hold_next = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset setup (local input, adaptive class).
    add_req(7'sd1, 7'sd1, 4'hF);        // arrived: first local consumer
    add_req(-7'sd1, -7'sd1, 4'hF);      // arrived again: count of one wraps
    add_req(7'sd0, 7'sd0, 4'h0);        // zero offsets: no try fires
    add_req(7'sd32, -7'sd32, 4'h0);     // adaptive own dimension, X+
    add_req(-7'sd32, 7'sd32, 4'h0);     // adaptive other dimension, Y+
    add_req(7'sd5, -7'sd5, 4'h0);       // dimension-order X with no bubble
    add_req(7'sd5, -7'sd5, 4'hF);
    add_req(-7'sd7, 7'sd1, 4'hF);       // skip to dimension-order X, granted
    add_req(7'sd1, -7'sd2, 4'h0);
    add_req(7'sd1, 7'sd3, 4'h0);        // dimension-order Y with no bubble
    add_req(7'sd63, -7'sd64, 4'hF);     // offsets at the ends of the 7-bit signed range
    add_req(-7'sd1, 7'sd1, 4'hF);
    add_req(7'sd0, 7'sd1, 4'hF);        // one dimension zero, other arrived
    add_req(7'sd1, 7'sd0, 4'hF);
    add_req(7'sd2, -7'sd2, 4'hF);
    add_req(-7'sd2, 7'sd2, 4'h5);
    add_req(7'sd31, -7'sd31, 4'hA);
    add_req(-7'sd31, 7'sd31, 4'h3);
    add_req(7'sd1, 7'sd1, 4'hF);
    add_req(-7'sd64, 7'sd63, 4'hC);
    hold_next = 1'b1;
    add_req(7'sd2, 7'sd1, 4'h0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        if (p == NUM_PHASES - 1) begin
          dir_tab[p] = 4'($urandom_range(0, 15));
          cls_tab[p] = 4'($urandom_range(0, 15));
          cnt_tab[p] = 4'($urandom_range(0, 15));
        end
        write_reg(REG_INPUT_DIRECTION, dir_tab[p]);
        write_reg(REG_INPUT_CHANNEL_CLASS, cls_tab[p]);
        write_reg(REG_LOCAL_PORT_COUNT, cnt_tab[p]);
      end
      fill_phase(PHASE_REQS);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && route_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
